// ----- rtl/cst_pkg.sv -----
// Shared types and constants for the collation source tokenizer.
// Holds the channel payload structs, the controller/datapath command and status
// structs, character codes and the keyword table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  // Input item: one source byte or an end-of-input mark.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } cst_in_t;

  // Result item: one token, or one byte of a token's text.
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        last_of_token;
    logic [15:0] line_number;
    logic        text_overflow;
  } cst_out_t;

  // Token kinds. Keyword kinds follow TK_CHARMAP in keyword table order.
  localparam logic [3:0] TK_END     = 4'd0;
  localparam logic [3:0] TK_SEP     = 4'd1;
  localparam logic [3:0] TK_NEWLINE = 4'd2;
  localparam logic [3:0] TK_QUOTED  = 4'd3;
  localparam logic [3:0] TK_SYMBOL  = 4'd4;
  localparam logic [3:0] TK_CHARMAP = 4'd5;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword table, each string right-aligned in 80 bits.
  localparam int KW_COUNT = 5;
  localparam logic [KW_COUNT-1:0][79:0] KW_STR = {
    80'("..."), 80'("order"), 80'("with"), 80'("substitute"), 80'("charmap")
  };
  localparam logic [KW_COUNT-1:0][3:0] KW_LEN = {4'd3, 4'd5, 4'd4, 4'd10, 4'd7};

  // Character at a position of a keyword; valid only below the keyword length.
  function automatic logic [7:0] kw_char(input int idx, input logic [3:0] pos);
    logic [79:0] s;
    logic [6:0]  sh;
    s  = KW_STR[idx];
    sh = 7'(({3'b000, KW_LEN[idx]} - 7'd1 - {3'b000, pos}) << 3);
    return s[sh +: 8];
  endfunction

  // Byte classes seen by the controller.
  typedef enum logic [2:0] {
    CLS_BLANK, CLS_QUOTE, CLS_SEP, CLS_HASH, CLS_NL, CLS_BSL, CLS_OTHER
  } cst_cls_t;

  // Text buffer operations.
  typedef enum logic [2:0] {
    TXT_HOLD, TXT_CLEAR, TXT_START, TXT_APPEND, TXT_BSL_MARK, TXT_BSL_ONLY,
    TXT_BSL_APPEND
  } cst_txt_op_t;

  // Output register loads.
  typedef enum logic [2:0] {
    OUT_NONE, OUT_SEP, OUT_NEWLINE, OUT_END, OUT_KEYWORD, OUT_EMPTY, OUT_DECODED
  } cst_out_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic        pend_ld;
    logic        use_pend;
    cst_txt_op_t txt_op;
    logic        line_inc;
    cst_out_op_t out_op;
    logic        dec_start;
    logic        dec_step;
    logic        word_text;
  } cst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cst_cls_t cls;
    logic     kw_hit;
    logic     text_empty;
    logic     slot_free;
    logic     dec_emit;
    logic     dec_end;
  } cst_sts_t;

endpackage

`default_nettype wire

// ----- rtl/cst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the token text buffer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/cst_dp.sv -----
// Datapath of the collation source tokenizer: byte classifier, text buffer,
// keyword match flags, line counter, escape decoder and output register.
// Depends on cst_pkg and cst_ram.
`timescale 1ns / 1ps
`default_nettype none

module cst_dp #(
  parameter int TEXT_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  cst_pkg::cst_cmd_t cmd,
  output cst_pkg::cst_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output cst_pkg::cst_out_t out_data
);
  import cst_pkg::*;

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int LW = AW + 4;
  localparam logic [AW-1:0] LEN_MAX = AW'(TEXT_DEPTH - 1);

  localparam logic [7:0] CH_D0 = 8'h30;
  localparam logic [7:0] CH_D7 = 8'h37;
  localparam logic [7:0] CH_D9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  typedef enum logic [1:0] {ESC_NONE, ESC_BSL, ESC_HEX, ESC_OCT} esc_t;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_D0 && c <= CH_D9) begin
      v = c - CH_D0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [2:0] oct_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_D0 && c <= CH_D7) begin
      v = c - CH_D0;
    end
    return v[2:0];
  endfunction

  logic [7:0]          pend_byte_r;
  logic [7:0]          cur_byte;
  cst_cls_t            cls;
  logic [AW-1:0]       length_r, length_nxt;
  logic                overflow_r, overflow_nxt;
  logic [KW_COUNT-1:0] kw_ok_r, kw_ok_nxt;
  logic [KW_COUNT-1:0] kw_hit_vec, kw_step, kw_first;
  logic [3:0]          kw_kind;
  logic [LW-1:0]       len_x;
  logic [15:0]         line_r, line_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  esc_t                esc_r, esc_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic                at_end;
  logic                dec_emit;
  logic [7:0]          dec_val;
  logic                ram_we;
  logic [AW-1:0]       ram_wr_addr;
  logic [7:0]          ram_wr_data;
  logic [7:0]          ram_rd_data;
  logic                slot_free;
  logic                out_valid_r, out_valid_nxt;
  cst_out_t            out_r, out_nxt;

  // The current byte is the input byte, or the held byte after a flush.
  assign cur_byte = cmd.use_pend ? pend_byte_r : in_byte;

  // Byte classifier.
  always_comb begin
    unique case (cur_byte) inside
      CH_SPACE, CH_TAB: cls = CLS_BLANK;
      CH_QUOTE:         cls = CLS_QUOTE;
      CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN,
      CH_LBRACE, CH_RBRACE, CH_LT, CH_GT: cls = CLS_SEP;
      CH_HASH:          cls = CLS_HASH;
      CH_NL:            cls = CLS_NL;
      CH_BSL:           cls = CLS_BSL;
      default:          cls = CLS_OTHER;
    endcase
  end

  // Keyword flags: one per keyword, narrowed on each kept character.
  assign len_x = LW'(length_r);

  always_comb begin
    kw_kind = TK_CHARMAP;
    for (int j = 0; j < KW_COUNT; j++) begin
      kw_hit_vec[j] = kw_ok_r[j] && (len_x == LW'(KW_LEN[j]));
      kw_step[j]    = kw_ok_r[j] && (len_x < LW'(KW_LEN[j])) &&
                      (cur_byte == kw_char(j, len_x[3:0]));
      kw_first[j]   = (cur_byte == kw_char(j, 4'd0));
      if (kw_hit_vec[j]) begin
        kw_kind = 4'(TK_CHARMAP + j);
      end
    end
  end

  // Text buffer updates.
  always_comb begin
    length_nxt   = length_r;
    overflow_nxt = overflow_r;
    kw_ok_nxt    = kw_ok_r;
    ram_we       = 1'b0;
    ram_wr_addr  = length_r;
    ram_wr_data  = cur_byte;
    unique case (cmd.txt_op)
      TXT_CLEAR: begin
        length_nxt   = '0;
        overflow_nxt = 1'b0;
      end
      TXT_START: begin
        ram_we       = 1'b1;
        ram_wr_addr  = '0;
        length_nxt   = AW'(1);
        overflow_nxt = 1'b0;
        kw_ok_nxt    = kw_first;
      end
      TXT_APPEND: begin
        if (length_r < LEN_MAX) begin
          ram_we     = 1'b1;
          length_nxt = length_r + 1'b1;
          kw_ok_nxt  = kw_step;
        end else begin
          overflow_nxt = 1'b1;
        end
      end
      TXT_BSL_MARK: begin
        ram_we       = 1'b1;
        ram_wr_addr  = '0;
        ram_wr_data  = CH_BSL;
        length_nxt   = '0;
        overflow_nxt = 1'b0;
        kw_ok_nxt    = '0;
      end
      TXT_BSL_ONLY: begin
        length_nxt = AW'(1);
        kw_ok_nxt  = '0;
      end
      TXT_BSL_APPEND: begin
        ram_we      = 1'b1;
        ram_wr_addr = AW'(1);
        length_nxt  = AW'(2);
        kw_ok_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  cst_ram #(
    .WIDTH(8),
    .DEPTH(TEXT_DEPTH)
  ) u_text_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(rd_ptr_r),
    .rd_data(ram_rd_data)
  );

  // Saturating line counter.
  assign line_nxt = (cmd.line_inc && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;

  // Escape decoder: consumes the buffered byte at the read pointer.
  assign at_end = ({1'b0, rd_ptr_r} + 1'b1) == {1'b0, length_r};

  always_comb begin
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    dec_emit = 1'b0;
    dec_val  = ram_rd_data;
    case (esc_r)
      ESC_NONE: begin
        if (ram_rd_data == CH_BSL) begin
          esc_nxt  = ESC_BSL;
          acc_nxt  = 8'd0;
          dec_emit = at_end;
          dec_val  = 8'd0;
        end else begin
          dec_emit = 1'b1;
        end
      end
      ESC_BSL: begin
        if (ram_rd_data == CH_LX) begin
          esc_nxt = ESC_HEX;
          acc_nxt = 8'd0;
          cnt_nxt = 2'd0;
        end else begin
          esc_nxt = ESC_OCT;
          acc_nxt = {5'd0, oct_val(ram_rd_data)};
          cnt_nxt = 2'd1;
        end
        dec_emit = at_end;
        dec_val  = acc_nxt;
      end
      ESC_HEX: begin
        acc_nxt  = {acc_r[3:0], hex_val(ram_rd_data)};
        cnt_nxt  = cnt_r + 2'd1;
        dec_emit = at_end || (cnt_r == 2'd1);
        dec_val  = acc_nxt;
        esc_nxt  = dec_emit ? ESC_NONE : ESC_HEX;
      end
      default: begin
        acc_nxt  = {acc_r[4:0], oct_val(ram_rd_data)};
        cnt_nxt  = cnt_r + 2'd1;
        dec_emit = at_end || (cnt_r == 2'd2);
        dec_val  = acc_nxt;
        esc_nxt  = dec_emit ? ESC_NONE : ESC_OCT;
      end
    endcase
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.dec_start) begin
      rd_ptr_nxt = '0;
    end else if (cmd.dec_step) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  // Output register with its load selection.
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = (cmd.out_op != OUT_NONE) || (out_valid_r && !out_ready);

  always_comb begin
    out_nxt               = out_r;
    out_nxt.line_number   = line_nxt;
    out_nxt.text_byte     = 8'd0;
    out_nxt.text_valid    = 1'b0;
    out_nxt.last_of_token = 1'b1;
    out_nxt.text_overflow = 1'b0;
    unique case (cmd.out_op)
      OUT_SEP: begin
        out_nxt.token_kind = TK_SEP;
        out_nxt.text_byte  = cur_byte;
        out_nxt.text_valid = 1'b1;
      end
      OUT_NEWLINE: out_nxt.token_kind = TK_NEWLINE;
      OUT_END:     out_nxt.token_kind = TK_END;
      OUT_KEYWORD: out_nxt.token_kind = kw_kind;
      OUT_EMPTY: begin
        out_nxt.token_kind    = cmd.word_text ? TK_SYMBOL : TK_QUOTED;
        out_nxt.text_overflow = overflow_r;
      end
      OUT_DECODED: begin
        out_nxt.token_kind    = cmd.word_text ? TK_SYMBOL : TK_QUOTED;
        out_nxt.text_byte     = dec_val;
        out_nxt.text_valid    = 1'b1;
        out_nxt.last_of_token = at_end;
        out_nxt.text_overflow = overflow_r;
      end
      default: out_nxt = out_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      overflow_r  <= 1'b0;
      kw_ok_r     <= '0;
      line_r      <= 16'd0;
      rd_ptr_r    <= '0;
      esc_r       <= ESC_NONE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      length_r    <= length_nxt;
      overflow_r  <= overflow_nxt;
      kw_ok_r     <= kw_ok_nxt;
      line_r      <= line_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      esc_r       <= cmd.dec_start ? ESC_NONE : (cmd.dec_step ? esc_nxt : esc_r);
      cnt_r       <= cmd.dec_step ? cnt_nxt : cnt_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.pend_ld) begin
      pend_byte_r <= in_byte;
    end
    if (cmd.dec_step) begin
      acc_r <= acc_nxt;
    end
    out_r <= out_nxt;
  end

  assign sts.cls        = cls;
  assign sts.kw_hit     = |kw_hit_vec;
  assign sts.text_empty = (length_r == '0);
  assign sts.slot_free  = slot_free;
  assign sts.dec_emit   = dec_emit;
  assign sts.dec_end    = at_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/cst_ctrl.sv -----
// Controller of the collation source tokenizer: scan mode and the sequencer
// that accepts bytes, flushes buffered text and emits trailing tokens.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_eoi,
  output logic              in_ready,
  input  cst_pkg::cst_sts_t sts,
  output cst_pkg::cst_cmd_t cmd
);
  import cst_pkg::*;

  typedef enum logic [2:0] {S_IN, S_FLUSH, S_RD, S_PROC, S_TAIL} state_t;
  typedef enum logic [2:0] {
    MODE_IDLE, MODE_STRING, MODE_COMMENT, MODE_WORD, MODE_SLASH
  } mode_t;
  typedef enum logic [1:0] {PEND_NONE, PEND_EOI, PEND_IDLE} pend_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  pend_t  pend_r, pend_nxt;
  logic   word_r, word_nxt;
  logic   accept;
  logic   tail_slot;

  assign in_ready = (state_r == S_IN) && sts.slot_free;
  assign accept   = in_valid && in_ready;

  // The trailing token after a flush needs the output register only for these.
  assign tail_slot = (pend_r == PEND_EOI) ||
                     ((pend_r == PEND_IDLE) && (sts.cls == CLS_SEP || sts.cls == CLS_NL));

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pend_nxt      = pend_r;
    word_nxt      = word_r;
    cmd           = '0;
    cmd.txt_op    = TXT_HOLD;
    cmd.out_op    = OUT_NONE;
    cmd.use_pend  = (state_r == S_TAIL);
    cmd.word_text = word_r;
    cmd.pend_ld   = accept;

    unique case (state_r)
      // Take one byte; most bytes finish here in the same cycle.
      S_IN: begin
        if (accept) begin
          if (in_eoi) begin
            unique case (mode_r)
              MODE_STRING: begin
                word_nxt  = 1'b0;
                pend_nxt  = PEND_EOI;
                state_nxt = S_FLUSH;
              end
              MODE_WORD: begin
                word_nxt  = 1'b1;
                pend_nxt  = PEND_EOI;
                state_nxt = S_FLUSH;
              end
              MODE_SLASH: begin
                cmd.txt_op = TXT_BSL_ONLY;
                word_nxt   = 1'b1;
                pend_nxt   = PEND_EOI;
                state_nxt  = S_FLUSH;
              end
              default: begin
                cmd.out_op = OUT_END;
                cmd.txt_op = TXT_CLEAR;
                mode_nxt   = MODE_IDLE;
              end
            endcase
          end else begin
            unique case (mode_r)
              MODE_IDLE: begin
                unique case (sts.cls)
                  CLS_BLANK: begin
                  end
                  CLS_QUOTE: begin
                    cmd.txt_op = TXT_CLEAR;
                    mode_nxt   = MODE_STRING;
                  end
                  CLS_SEP:  cmd.out_op = OUT_SEP;
                  CLS_HASH: mode_nxt = MODE_COMMENT;
                  CLS_NL: begin
                    cmd.line_inc = 1'b1;
                    cmd.out_op   = OUT_NEWLINE;
                  end
                  CLS_BSL: begin
                    cmd.txt_op = TXT_BSL_MARK;
                    mode_nxt   = MODE_SLASH;
                  end
                  default: begin
                    cmd.txt_op = TXT_START;
                    mode_nxt   = MODE_WORD;
                  end
                endcase
              end
              MODE_STRING: begin
                if (sts.cls == CLS_QUOTE) begin
                  word_nxt  = 1'b0;
                  pend_nxt  = PEND_NONE;
                  state_nxt = S_FLUSH;
                end else begin
                  cmd.txt_op = TXT_APPEND;
                end
              end
              MODE_COMMENT: begin
                if (sts.cls == CLS_NL) begin
                  cmd.line_inc = 1'b1;
                  cmd.out_op   = OUT_NEWLINE;
                  mode_nxt     = MODE_IDLE;
                end
              end
              MODE_SLASH: begin
                unique case (sts.cls) inside
                  CLS_NL: begin
                    cmd.line_inc = 1'b1;
                    mode_nxt     = MODE_IDLE;
                  end
                  CLS_BLANK, CLS_HASH, CLS_SEP: begin
                    cmd.txt_op = TXT_BSL_ONLY;
                    word_nxt   = 1'b1;
                    pend_nxt   = PEND_IDLE;
                    state_nxt  = S_FLUSH;
                  end
                  default: begin
                    cmd.txt_op = TXT_BSL_APPEND;
                    mode_nxt   = MODE_WORD;
                  end
                endcase
              end
              default: begin
                unique case (sts.cls) inside
                  CLS_BLANK, CLS_HASH, CLS_SEP, CLS_NL: begin
                    word_nxt  = 1'b1;
                    pend_nxt  = PEND_IDLE;
                    state_nxt = S_FLUSH;
                  end
                  default: cmd.txt_op = TXT_APPEND;
                endcase
              end
            endcase
          end
        end
      end

      // Start a flush: keyword token, empty string, or a pass over the buffer.
      S_FLUSH: begin
        if (word_r && sts.kw_hit) begin
          if (sts.slot_free) begin
            cmd.out_op = OUT_KEYWORD;
            state_nxt  = S_TAIL;
          end
        end else if (sts.text_empty) begin
          if (sts.slot_free) begin
            cmd.out_op = OUT_EMPTY;
            state_nxt  = S_TAIL;
          end
        end else begin
          cmd.dec_start = 1'b1;
          state_nxt     = S_RD;
        end
      end

      // Buffer read in flight.
      S_RD: state_nxt = S_PROC;

      // Decode one buffered byte; stall while a result cannot be placed.
      S_PROC: begin
        if (!sts.dec_emit || sts.slot_free) begin
          cmd.dec_step = 1'b1;
          cmd.out_op   = sts.dec_emit ? OUT_DECODED : OUT_NONE;
          state_nxt    = sts.dec_end ? S_TAIL : S_RD;
        end
      end

      // Handle the byte or end mark that closed the token.
      default: begin
        if (!tail_slot || sts.slot_free) begin
          cmd.txt_op = TXT_CLEAR;
          mode_nxt   = MODE_IDLE;
          state_nxt  = S_IN;
          if (pend_r == PEND_EOI) begin
            cmd.out_op = OUT_END;
          end else if (pend_r == PEND_IDLE) begin
            unique case (sts.cls)
              CLS_SEP:  cmd.out_op = OUT_SEP;
              CLS_HASH: mode_nxt = MODE_COMMENT;
              CLS_NL: begin
                cmd.line_inc = 1'b1;
                cmd.out_op   = OUT_NEWLINE;
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      mode_r  <= MODE_IDLE;
      pend_r  <= PEND_NONE;
      word_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/collation_source_tokenizer.sv -----
// Collation source tokenizer: top level joining the controller and datapath.
// Depends on cst_pkg, cst_ctrl, cst_dp and cst_ram.
//
// Usage:
// - Input channel (in_valid/in_ready/in_data) takes one source byte per
//   transfer, or an end-of-input mark. Result channel (out_valid/out_ready/
//   out_data) gives tokens and decoded text bytes, one per transfer.
// - Blanks, comments, string bodies and word characters are handled in the cycle in which they are taken.
//   Separators and newlines give their token in the cycle after the transfer.
// - A byte that closes a string or word starts a flush: a set-up state, then a
//   text buffer read and then a decode step for each buffered byte, then the
//   closing token. Keywords and empty strings are placed in the set-up state
//   and skip the buffer pass. The buffer's registered read is why each byte
//   needs a read step before its decode.
// - Input is taken only while the output register is free or being drained.
//   When the receiver stalls, the result holds in the output register and the
//   block stops at the next result it has to place.
// - After reset the block is between tokens, at line zero, with an empty
//   buffer; in_ready is high once reset is released.
// - TEXT_DEPTH sets the text buffer; it keeps TEXT_DEPTH-1 characters.
`timescale 1ns / 1ps
`default_nettype none

module collation_source_tokenizer #(
  parameter int TEXT_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cst_pkg::cst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cst_pkg::cst_out_t out_data
);
  import cst_pkg::*;

  cst_cmd_t cmd;
  cst_sts_t sts;

  // Sequencer.
  cst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_eoi  (in_data.end_of_input),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Buffer, decoder and output register.
  cst_dp #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_data.source_byte),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
